>>> rtl/core/nzcs_pkg.sv
// ----------------------------------------------------------------------------
// nzcs_pkg: shared definitions for the nearest zero-crossing snap core
// Default widths, item codes and configuration register indexes.
// ----------------------------------------------------------------------------
package nzcs_pkg;

    // Default widths of the position, reach and sample fields.
    localparam int POSITION_BITS_DEF = 40;
    localparam int REACH_BITS_DEF    = 20;
    localparam int SAMPLE_BITS_DEF   = 24;

    // A window shorter than this many frames never snaps.
    localparam int MIN_FRAMES = 3;

    // Channel count after reset.
    localparam logic [1:0] CHANNELS_RESET = 2'd2;

    // Item kind carried in s_tuser.
    typedef enum logic {
        MODE_FRAME  = 1'b0,
        MODE_FINISH = 1'b1
    } mode_t;

    // Configuration register indexes.
    localparam int CFG_INDEX_BITS = 2;
    localparam logic [CFG_INDEX_BITS-1:0] REG_REQUESTED_POSITION = 2'd0;
    localparam logic [CFG_INDEX_BITS-1:0] REG_SEARCH_REACH       = 2'd1;
    localparam logic [CFG_INDEX_BITS-1:0] REG_CHANNEL_COUNT      = 2'd2;

endpackage

>>> rtl/core/nearest_zero_crossing_snap_core.sv
// ----------------------------------------------------------------------------
// nearest_zero_crossing_snap_core: snap a cut position to a zero crossing
// Streams the frames of a search window, tracks the crossing of the
// channel sum nearest the window centre and reports it on a finish item.
// ----------------------------------------------------------------------------
// The host writes the requested position, the reach and the channel count,
// then streams the window's frames (s_tuser = 0) starting at
// max(0, position - reach), and closes with a finish item (s_tuser = 1).
// One item is taken every cycle while the result side is free; each item
// passes an input stage that forms the channel sum and a second stage that
// updates the running search and the result register, so a result is
// offered once its finish item has passed both stages. Frames past the
// end of the window are taken and dropped. The result gives the snapped
// position, or the requested position with crossing_found low when the
// window held fewer than three frames or no crossing.
module nearest_zero_crossing_snap_core
    import nzcs_pkg::*;
#(
    parameter int POSITION_BITS = POSITION_BITS_DEF,
    parameter int REACH_BITS    = REACH_BITS_DEF,
    parameter int SAMPLE_BITS   = SAMPLE_BITS_DEF,
    localparam int CFG_BITS     = (POSITION_BITS > REACH_BITS) ? POSITION_BITS : REACH_BITS,
    localparam int S_TDATA_W    = ((2 * SAMPLE_BITS + 7) / 8) * 8,
    localparam int M_TDATA_W    = ((POSITION_BITS + 7) / 8) * 8
) (
    input  logic                      aclk,
    input  logic                      aresetn,

    // Configuration write port.
    input  logic                      cfg_wr_en,
    input  logic [CFG_INDEX_BITS-1:0] cfg_index,
    input  logic [CFG_BITS-1:0]       cfg_wdata,

    // Input items.
    input  logic                      s_tvalid,
    output logic                      s_tready,
    input  logic [S_TDATA_W-1:0]      s_tdata,   // sample_left, sample_right, zero pad
    input  logic                      s_tuser,   // mode

    // Result items.
    output logic                      m_tvalid,
    input  logic                      m_tready,
    output logic [M_TDATA_W-1:0]      m_tdata,   // snapped_position, zero pad
    output logic                      m_tuser    // crossing_found
);

    localparam int IDX_BITS = REACH_BITS + 2;
    localparam int SUM_BITS = SAMPLE_BITS + 1;
    localparam int EXT_BITS = (CFG_BITS > IDX_BITS) ? CFG_BITS : IDX_BITS;

    // Configuration registers.
    logic [POSITION_BITS-1:0] req_pos_reg;
    logic [REACH_BITS-1:0]    reach_reg;
    logic [1:0]               channels_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            req_pos_reg  <= '0;
            reach_reg    <= '0;
            channels_reg <= CHANNELS_RESET;
        end else if (cfg_wr_en) begin
            case (cfg_index)
                REG_REQUESTED_POSITION: req_pos_reg  <= cfg_wdata[POSITION_BITS-1:0];
                REG_SEARCH_REACH:       reach_reg    <= cfg_wdata[REACH_BITS-1:0];
                REG_CHANNEL_COUNT:      channels_reg <= cfg_wdata[1:0];
                default: ;
            endcase
        end
    end

    // Window geometry: the centre offset is min(position, reach).
    logic [EXT_BITS-1:0]      req_ext;
    logic [EXT_BITS-1:0]      reach_ext;
    logic [REACH_BITS-1:0]    centre;
    logic [IDX_BITS-1:0]      centre_idx;
    logic [IDX_BITS-1:0]      limit;

    assign req_ext    = EXT_BITS'(req_pos_reg);
    assign reach_ext  = EXT_BITS'(reach_reg);
    assign centre     = (req_ext < reach_ext) ? req_ext[REACH_BITS-1:0] : reach_reg;
    assign centre_idx = IDX_BITS'(centre);
    assign limit      = centre_idx + IDX_BITS'(reach_reg) + IDX_BITS'(1);

    // Handshake: the pipeline moves whenever the result register is free.
    logic m_valid_reg;
    logic out_free;
    logic st1_valid_reg;
    logic advance;

    assign out_free = !m_valid_reg || m_tready;
    assign advance  = st1_valid_reg && out_free;
    assign s_tready = !st1_valid_reg || out_free;

    // Input stage: register the item kind and the channel sum.
    logic                       st1_finish_reg;
    logic signed [SUM_BITS-1:0] st1_sum_reg;
    logic signed [SUM_BITS-1:0] sum_left;
    logic signed [SUM_BITS-1:0] sum_right;

    assign sum_left  = SUM_BITS'(signed'(s_tdata[SAMPLE_BITS-1:0]));
    assign sum_right = channels_reg[1] ? SUM_BITS'(signed'(s_tdata[2*SAMPLE_BITS-1:SAMPLE_BITS]))
                                       : '0;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            st1_valid_reg <= 1'b0;
        end else if (s_tready) begin
            st1_valid_reg <= s_tvalid;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_tready && s_tvalid) begin
            st1_finish_reg <= (s_tuser == MODE_FINISH);
            st1_sum_reg    <= sum_left + sum_right;
        end
    end

    // Search state.
    logic signed [SUM_BITS-1:0] prev_sum_reg;
    logic [IDX_BITS-1:0]        frame_idx_reg;
    logic [IDX_BITS-1:0]        best_idx_reg;
    logic [IDX_BITS-1:0]        best_dist_reg;
    logic                       have_cross_reg;

    // Crossing test against the previous frame and distance to the centre.
    logic                is_cross;
    logic                in_window;
    logic [IDX_BITS-1:0] cross_dist;
    logic                take_best;

    assign is_cross   = (prev_sum_reg == '0) || (st1_sum_reg == '0)
                     || (prev_sum_reg[SUM_BITS-1] != st1_sum_reg[SUM_BITS-1]);
    assign in_window  = frame_idx_reg < limit;
    assign cross_dist = (frame_idx_reg >= centre_idx) ? frame_idx_reg - centre_idx
                                                      : centre_idx - frame_idx_reg;
    assign take_best  = (frame_idx_reg != '0) && is_cross
                     && (!have_cross_reg || cross_dist < best_dist_reg);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            prev_sum_reg   <= '0;
            frame_idx_reg  <= '0;
            best_idx_reg   <= '0;
            best_dist_reg  <= '1;
            have_cross_reg <= 1'b0;
        end else if (advance) begin
            if (st1_finish_reg) begin
                prev_sum_reg   <= '0;
                frame_idx_reg  <= '0;
                best_idx_reg   <= '0;
                best_dist_reg  <= '1;
                have_cross_reg <= 1'b0;
            end else if (in_window) begin
                if (take_best) begin
                    best_idx_reg   <= frame_idx_reg;
                    best_dist_reg  <= cross_dist;
                    have_cross_reg <= 1'b1;
                end
                prev_sum_reg  <= st1_sum_reg;
                frame_idx_reg <= frame_idx_reg + IDX_BITS'(1);
            end
        end
    end

    // Result: window start plus best index, wrapped to the position width, or the requested position when none found.
    logic                     found;
    logic [EXT_BITS-1:0]      snap_ext;
    logic [POSITION_BITS-1:0] pos_next;
    logic [POSITION_BITS-1:0] pos_reg;
    logic                     found_reg;

    assign found    = (frame_idx_reg >= IDX_BITS'(MIN_FRAMES)) && have_cross_reg;
    assign snap_ext = req_ext - EXT_BITS'(centre) + EXT_BITS'(best_idx_reg);
    assign pos_next = found ? snap_ext[POSITION_BITS-1:0] : req_pos_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (advance && st1_finish_reg) begin
            m_valid_reg <= 1'b1;
        end else if (m_tready) begin
            m_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (advance && st1_finish_reg) begin
            pos_reg   <= pos_next;
            found_reg <= found;
        end
    end

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = M_TDATA_W'(pos_reg);
    assign m_tuser  = found_reg;

    // A finish item leaves the search state cleared.
    assert property (@(posedge aclk) disable iff (!aresetn)
        advance && st1_finish_reg |=> frame_idx_reg == '0 && !have_cross_reg)
        else $error("search state not cleared after finish item");

    // The kept crossing always lies between the first and the latest frame.
    assert property (@(posedge aclk) disable iff (!aresetn)
        have_cross_reg |-> best_idx_reg != '0 && best_idx_reg < frame_idx_reg)
        else $error("best crossing index outside the frames seen");

    // A result only appears after a finish item left the input stage.
    assert property (@(posedge aclk) disable iff (!aresetn)
        $rose(m_valid_reg) |-> $past(advance && st1_finish_reg))
        else $error("result produced without a finish item");

endmodule
